>>> hdl/run_request_and_duty_target_core_defines.svh
// assertion macros for the run request and duty target core
`ifndef RUN_REQUEST_AND_DUTY_TARGET_CORE_DEFINES_SVH
`define RUN_REQUEST_AND_DUTY_TARGET_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RRDT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrdt check failed");

// next-cycle implication, checked outside reset
`define RRDT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrdt check failed");

`endif

>>> hdl/rrdt_pkg.sv
// shared types and constants of the run request and duty target core
`timescale 1ns / 1ps
`default_nettype none

package rrdt_pkg;

    // operating modes
    localparam logic [1:0] MODE_BUTTONS  = 2'd0;
    localparam logic [1:0] MODE_POT      = 2'd1;
    localparam logic [1:0] MODE_COMBINED = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_START_TH  = 3'd1;
    localparam logic [2:0] REG_STOP_TH   = 3'd2;
    localparam logic [2:0] REG_UPPER     = 3'd3;
    localparam logic [2:0] REG_LOWER     = 3'd4;
    localparam logic [2:0] REG_DUTY_FS   = 3'd5;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned DIV_STEPS = 16;

    typedef struct packed {
        logic               start_button;
        logic               stop_button;
        logic signed [15:0] pot_reading;
    } in_item_t;

    typedef struct packed {
        logic        running;
        logic [15:0] duty_target;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] start_threshold;
        logic [15:0] stop_threshold;
        logic [15:0] upper_limit;
        logic [15:0] lower_limit;
        logic [15:0] duty_full_scale;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_HOLD
    } state_t;

endpackage

`default_nettype wire

>>> hdl/rrdt_regs.sv
// configuration register file behind the apb port
`timescale 1ns / 1ps
`default_nettype none

module rrdt_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rrdt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rrdt_pkg::DATA_W-1:0]  pwdata,
    output logic      [rrdt_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output rrdt_pkg::cfg_t                    cfg
);

    rrdt_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_index;
    logic           wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[rrdt_pkg::ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= rrdt_pkg::MODE_BUTTONS;
            cfg_reg.start_threshold <= 16'd0;
            cfg_reg.stop_threshold  <= 16'd0;
            cfg_reg.upper_limit     <= 16'hffff;
            cfg_reg.lower_limit     <= 16'd0;
            cfg_reg.duty_full_scale <= 16'hffff;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                rrdt_pkg::REG_MODE:     cfg_reg.mode            <= pwdata[1:0];
                rrdt_pkg::REG_START_TH: cfg_reg.start_threshold <= pwdata[15:0];
                rrdt_pkg::REG_STOP_TH:  cfg_reg.stop_threshold  <= pwdata[15:0];
                rrdt_pkg::REG_UPPER:    cfg_reg.upper_limit     <= pwdata[15:0];
                rrdt_pkg::REG_LOWER:    cfg_reg.lower_limit     <= pwdata[15:0];
                rrdt_pkg::REG_DUTY_FS:  cfg_reg.duty_full_scale <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_index)
            rrdt_pkg::REG_MODE:     prdata = {30'd0, cfg_reg.mode};
            rrdt_pkg::REG_START_TH: prdata = {16'd0, cfg_reg.start_threshold};
            rrdt_pkg::REG_STOP_TH:  prdata = {16'd0, cfg_reg.stop_threshold};
            rrdt_pkg::REG_UPPER:    prdata = {16'd0, cfg_reg.upper_limit};
            rrdt_pkg::REG_LOWER:    prdata = {16'd0, cfg_reg.lower_limit};
            rrdt_pkg::REG_DUTY_FS:  prdata = {16'd0, cfg_reg.duty_full_scale};
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/rrdt_divider.sv
// restoring divider, one quotient bit per cycle, quotient known to fit 16 bits
`timescale 1ns / 1ps
`default_nettype none

module rrdt_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [15:0]      quotient
);

    logic [15:0] rem_reg,  rem_next;
    logic [15:0] quo_reg,  quo_next;
    logic [15:0] den_reg,  den_next;
    logic [3:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [16:0] shifted;
    logic [16:0] trial;
    logic        fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // shared subtract and compare unit
    assign shifted = {rem_reg, quo_reg[15]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    // step control
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[31:16];
            quo_next  = dividend[15:0];
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[15:0] : shifted[15:0];
            quo_next = {quo_reg[14:0], fits};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(rrdt_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

`default_nettype wire

>>> hdl/run_request_and_duty_target_core.sv
// run request and duty target core: flag update, clamp, scale sequencer
// unscaled path in button mode, mode 3, or limits not ordered: input transfer, hold, result register;
// scaled path for the duty target: multiply and divider load, 16 divider steps,
// quotient load, result register.
// items pass through the sequencer one at a time;
// a new item is taken as soon as the sequencer is idle, even with a result still waiting.
`timescale 1ns / 1ps
`default_nettype none

module run_request_and_duty_target_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire rrdt_pkg::in_item_t           in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output rrdt_pkg::out_item_t               out_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rrdt_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rrdt_pkg::DATA_W-1:0]  pwdata,
    output logic      [rrdt_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);

    rrdt_pkg::cfg_t      cfg;
    rrdt_pkg::state_t    state_reg, state_next;

    logic                run_reg, run_next;
    logic                start_prev_reg, start_prev_next;
    logic                stop_prev_reg, stop_prev_next;
    logic [15:0]         duty_hold_reg, duty_hold_next;
    logic [15:0]         diff_reg, diff_next;
    logic [15:0]         span_reg, span_next;
    logic                out_valid_reg, out_valid_next;
    rrdt_pkg::out_item_t out_data_reg, out_data_next;

    logic                accept;
    logic                div_start;
    logic                div_done;
    logic [15:0]         div_quotient;
    logic [31:0]         product;

    logic signed [16:0]  v_ext;
    logic signed [16:0]  hi_ext;
    logic signed [16:0]  lo_ext;
    logic signed [16:0]  start_ext;
    logic signed [16:0]  stop_ext;
    logic [15:0]         v_clamp;
    logic                limits_ok;
    logic                start_fall;
    logic                stop_fall;
    logic                btn_run;

    rrdt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // multiply feeds the divider's input registers
    assign product   = {16'd0, cfg.duty_full_scale} * {16'd0, diff_reg};
    assign div_start = (state_reg == rrdt_pkg::ST_MUL);

    rrdt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign in_ready  = (state_reg == rrdt_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // signed compares of the reading against unsigned settings
    assign v_ext     = {in_data.pot_reading[15], in_data.pot_reading};
    assign hi_ext    = signed'({1'b0, cfg.upper_limit});
    assign lo_ext    = signed'({1'b0, cfg.lower_limit});
    assign start_ext = signed'({1'b0, cfg.start_threshold});
    assign stop_ext  = signed'({1'b0, cfg.stop_threshold});
    assign limits_ok = cfg.upper_limit > cfg.lower_limit;

    // clamp to the limits
    always_comb
    begin
        if (v_ext > hi_ext)
        begin
            v_clamp = cfg.upper_limit;
        end
        else if (v_ext < lo_ext)
        begin
            v_clamp = cfg.lower_limit;
        end
        else
        begin
            v_clamp = v_ext[15:0];
        end
    end

    // button edge detection
    assign start_fall = !in_data.start_button && start_prev_reg;
    assign stop_fall  = !in_data.stop_button && stop_prev_reg;
    assign btn_run    = run_reg ? !stop_fall : start_fall;

    // sequencer next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        run_next        = run_reg;
        start_prev_next = start_prev_reg;
        stop_prev_next  = stop_prev_reg;
        duty_hold_next  = duty_hold_reg;
        diff_next       = diff_reg;
        span_next       = span_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        unique case (state_reg)
            rrdt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    diff_next  = v_clamp - cfg.lower_limit;
                    span_next  = cfg.upper_limit - cfg.lower_limit;
                    state_next = rrdt_pkg::ST_HOLD;
                    case (cfg.mode) inside
                        rrdt_pkg::MODE_BUTTONS:
                        begin
                            run_next        = btn_run;
                            start_prev_next = in_data.start_button;
                            stop_prev_next  = in_data.stop_button;
                            duty_hold_next  = cfg.duty_full_scale;
                        end
                        rrdt_pkg::MODE_POT, rrdt_pkg::MODE_COMBINED:
                        begin
                            if (cfg.mode == rrdt_pkg::MODE_POT)
                            begin
                                if (v_ext > start_ext)
                                begin
                                    run_next = 1'b1;
                                end
                                else if (v_ext < stop_ext)
                                begin
                                    run_next = 1'b0;
                                end
                            end
                            else
                            begin
                                run_next        = btn_run;
                                start_prev_next = in_data.start_button;
                                stop_prev_next  = in_data.stop_button;
                            end
                            if (limits_ok)
                            begin
                                state_next = rrdt_pkg::ST_MUL;
                            end
                            else
                            begin
                                duty_hold_next = 16'd0;
                            end
                        end
                        default:
                        begin
                            // unused mode: run flag and held duty stay as they are
                        end
                    endcase
                end
            end
            rrdt_pkg::ST_MUL:
            begin
                state_next = rrdt_pkg::ST_DIV;
            end
            rrdt_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    duty_hold_next = div_quotient;
                    state_next     = rrdt_pkg::ST_HOLD;
                end
            end
            rrdt_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.running     = run_reg;
                    out_data_next.duty_target = duty_hold_reg;
                    state_next                = rrdt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrdt_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rrdt_pkg::ST_IDLE;
            run_reg        <= 1'b0;
            start_prev_reg <= 1'b0;
            stop_prev_reg  <= 1'b0;
            duty_hold_reg  <= 16'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            run_reg        <= run_next;
            start_prev_reg <= start_prev_next;
            stop_prev_reg  <= stop_prev_next;
            duty_hold_reg  <= duty_hold_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        diff_reg     <= diff_next;
        span_reg     <= span_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

>>> hdl/rrdt_checker.sv
// port-level checks of the run request and duty target core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "run_request_and_duty_target_core_defines.svh"

module rrdt_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         in_valid,
    input wire logic                         in_ready,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire rrdt_pkg::out_item_t          out_data,
    input wire logic                         psel,
    input wire logic                         penable,
    input wire logic                         pwrite,
    input wire logic                         pready
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // sequencer is busy right after taking an item
    `RRDT_ASSERT_NXT(a_busy_after_xfer, clk, rst_n, in_xfer, !in_ready)

    // a fresh result is only loaded while the sequencer was busy
    `RRDT_ASSERT_IMP(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(!in_ready))

    // a waiting result holds
    `RRDT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data))

    // apb side never stalls a write
    `RRDT_ASSERT_IMP(a_cfg_no_wait, clk, rst_n, psel && penable && pwrite, pready)

endmodule

bind run_request_and_duty_target_core rrdt_checker u_rrdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready)
);

`default_nettype wire

>>> tb/sv/run_request_and_duty_target_core_check.sv
// checker for the run request and duty target core: tracks registers, predicts and compares results
`timescale 1ns / 1ps

module run_request_and_duty_target_core_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  rrdt_pkg::in_item_t               in_data,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  rrdt_pkg::out_item_t              out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [rrdt_pkg::ADDR_W-1:0]      paddr,
    input  logic [rrdt_pkg::DATA_W-1:0]      pwdata,
    output int                               failures,
    output int                               pending
);

    // register copies, at their reset values
    logic [1:0]  mode_reg  = rrdt_pkg::MODE_BUTTONS;
    logic [15:0] start_th  = 16'd0;
    logic [15:0] stop_th   = 16'd0;
    logic [15:0] upper_lim = 16'hffff;
    logic [15:0] lower_lim = 16'd0;
    logic [15:0] duty_fs   = 16'hffff;

    // predicted block state
    logic        run_request = 1'b0;
    logic        start_prev  = 1'b0;
    logic        stop_prev   = 1'b0;
    logic [15:0] held_duty   = 16'd0;

    rrdt_pkg::out_item_t expected_q[$];
    int                  fail_count    = 0;
    int                  pending_count = 0;

    assign failures = fail_count;
    assign pending  = pending_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // falling edge on start sets the flag while stopped, on stop clears it while running
    function automatic void take_button_edges(input logic start_lvl, input logic stop_lvl);
        if (!run_request)
        begin
            if (!start_lvl && start_prev)
                run_request = 1'b1;
        end
        else if (!stop_lvl && stop_prev)
        begin
            run_request = 1'b0;
        end
        start_prev = start_lvl;
        stop_prev  = stop_lvl;
    endfunction

    // clamp to the limits, then scale to the full-scale duty, truncated; zero when the limits are not ordered
    function automatic logic [15:0] scaled_duty(input int reading);
        int                v;
        int                hi;
        int                lo;
        longint unsigned   prod;
        v  = reading;
        hi = int'(upper_lim);
        lo = int'(lower_lim);
        if (v > hi)
            v = hi;
        else if (v < lo)
            v = lo;
        if (hi <= lo)
            return 16'd0;
        prod = 64'(duty_fs) * 64'(v - lo);
        return 16'(prod / 64'(hi - lo));
    endfunction

    // one control tick of the predictor
    function automatic void run_tick(input rrdt_pkg::in_item_t tick);
        int reading;
        reading = $signed(tick.pot_reading);
        case (mode_reg)
            rrdt_pkg::MODE_BUTTONS:
            begin
                take_button_edges(tick.start_button, tick.stop_button);
                held_duty = duty_fs;
            end
            rrdt_pkg::MODE_POT:
            begin
                if (reading > int'(start_th))
                    run_request = 1'b1;
                else if (reading < int'(stop_th))
                    run_request = 1'b0;
                held_duty = scaled_duty(reading);
            end
            rrdt_pkg::MODE_COMBINED:
            begin
                take_button_edges(tick.start_button, tick.stop_button);
                held_duty = scaled_duty(reading);
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rrdt_pkg::out_item_t want;
        if (!rst_n)
        begin
            mode_reg    = rrdt_pkg::MODE_BUTTONS;
            start_th    = 16'd0;
            stop_th     = 16'd0;
            upper_lim   = 16'hffff;
            lower_lim   = 16'd0;
            duty_fs     = 16'hffff;
            run_request = 1'b0;
            start_prev  = 1'b0;
            stop_prev   = 1'b0;
            held_duty   = 16'd0;
            expected_q.delete();
            pending_count = 0;
        end
        else
        begin
            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[rrdt_pkg::ADDR_W-1:2])
                    rrdt_pkg::REG_MODE:     mode_reg  = pwdata[1:0];
                    rrdt_pkg::REG_START_TH: start_th  = pwdata[15:0];
                    rrdt_pkg::REG_STOP_TH:  stop_th   = pwdata[15:0];
                    rrdt_pkg::REG_UPPER:    upper_lim = pwdata[15:0];
                    rrdt_pkg::REG_LOWER:    lower_lim = pwdata[15:0];
                    rrdt_pkg::REG_DUTY_FS:  duty_fs   = pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end

            // result transfer against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with no tick pending: running %b duty %0d",
                                              out_data.running, out_data.duty_target));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.running !== want.running)
                        report_mismatch($sformatf("running: expected %b got %b",
                                                  want.running, out_data.running));
                    if (out_data.duty_target !== want.duty_target)
                        report_mismatch($sformatf("duty_target: expected %0d got %0d",
                                                  want.duty_target, out_data.duty_target));
                end
            end

            // tick transfer
            if (in_valid && in_ready)
            begin
                run_tick(in_data);
                want.running     = run_request;
                want.duty_target = held_duty;
                expected_q.push_back(want);
            end
            pending_count = expected_q.size();
        end
    end

endmodule

>>> tb/sv/run_request_and_duty_target_core_test.sv
// testbench top for the run request and duty target core: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module run_request_and_duty_target_core_test;

    // unused mode value and register slots beyond the map
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int PHASES       = 16;
    localparam int PHASE_TICKS  = 100;
    localparam int TAIL_CYCLES  = 40;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    rrdt_pkg::in_item_t            in_data = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    rrdt_pkg::out_item_t           out_data;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [rrdt_pkg::ADDR_W-1:0]   paddr = '0;
    logic [rrdt_pkg::DATA_W-1:0]   pwdata = '0;
    logic [rrdt_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    int                            failures;
    int                            pending;

    // stimulus shaping
    bit                  steady = 1'b0;
    int                  cfg_start = 0;
    int                  cfg_stop = 0;
    int                  cfg_upper = 65535;
    int                  cfg_lower = 0;
    logic signed [15:0]  walk_reading = '0;

    run_request_and_duty_target_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    run_request_and_duty_target_core_check tick_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .failures  (failures),
        .pending   (pending)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #6000000;
        $display("run_request_and_duty_target_core_test failed");
        $finish;
    end

    // result side stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready <= steady || ($urandom_range(99) >= 34);
        end
    end

    function automatic bit sender_idles();
        return !steady && ($urandom_range(99) < 34);
    endfunction

    // register write: setup then access, junk in the unused upper bits
    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        case (index)
            rrdt_pkg::REG_START_TH: cfg_start = value;
            rrdt_pkg::REG_STOP_TH:  cfg_stop  = value;
            rrdt_pkg::REG_UPPER:    cfg_upper = value;
            rrdt_pkg::REG_LOWER:    cfg_lower = value;
            default:
            begin
            end
        endcase
    endtask

    task automatic load_config(input logic [1:0] mode_val, input logic [15:0] start_val,
                               input logic [15:0] stop_val, input logic [15:0] upper_val,
                               input logic [15:0] lower_val, input logic [15:0] fs_val);
        write_reg(rrdt_pkg::REG_MODE, {14'($urandom), mode_val});
        write_reg(rrdt_pkg::REG_START_TH, start_val);
        write_reg(rrdt_pkg::REG_STOP_TH, stop_val);
        write_reg(rrdt_pkg::REG_UPPER, upper_val);
        write_reg(rrdt_pkg::REG_LOWER, lower_val);
        write_reg(rrdt_pkg::REG_DUTY_FS, fs_val);
    endtask

    // one tick transfer, called and returning just after a falling edge
    task automatic send_tick(input logic start_b, input logic stop_b,
                             input logic signed [15:0] reading);
        if (sender_idles())
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while (sender_idles());
        end
        in_valid <= 1'b1;
        in_data  <= '{start_b, stop_b, reading};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    function automatic logic [15:0] pick_threshold();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'd0;
        if (r < 15) return 16'hffff;
        if (r < 20) return 16'h7fff;
        if (r < 25) return 16'h8000;
        return 16'($urandom_range(32767));
    endfunction

    // readings: uniform, near a threshold or limit, extremes, or a slow walk
    function automatic logic signed [15:0] pick_reading();
        int r;
        int point;
        r = $urandom_range(99);
        if (r < 30)
            return 16'($urandom);
        if (r < 60)
        begin
            case ($urandom_range(4))
                0: point = cfg_start;
                1: point = cfg_stop;
                2: point = cfg_upper;
                3: point = cfg_lower;
                default: point = 0;
            endcase
            return 16'(point + $urandom_range(16) - 8);
        end
        if (r < 70)
        begin
            case ($urandom_range(3))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return -16'sd1;
                default: return 16'sd0;
            endcase
        end
        walk_reading = walk_reading + 16'($urandom_range(512)) - 16'd256;
        return walk_reading;
    endfunction

    initial
    begin : stimulus
        logic [1:0]  mode_val;
        logic [15:0] start_val;
        logic [15:0] stop_val;
        logic [15:0] upper_val;
        logic [15:0] lower_val;
        logic [15:0] fs_val;
        logic        start_lvl;
        logic        stop_lvl;
        int          r;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // button mode at reset values: edges, presses while running, extremes
        send_tick(1'b1, 1'b1, 16'sd0);
        send_tick(1'b0, 1'b1, 16'sh8000);
        send_tick(1'b0, 1'b1, 16'sh7fff);
        send_tick(1'b1, 1'b0, -16'sd1);
        send_tick(1'b0, 1'b0, 16'sd1);
        drain();

        // potentiometer mode: hysteresis, clamps, negative readings
        load_config(rrdt_pkg::MODE_POT, 16'd1000, 16'd500, 16'd4000, 16'd200, 16'hffff);
        send_tick(1'b1, 1'b1, 16'sh8000);
        send_tick(1'b1, 1'b1, 16'sd1001);
        send_tick(1'b0, 1'b0, 16'sd750);
        send_tick(1'b1, 1'b1, 16'sd499);
        send_tick(1'b1, 1'b1, 16'sd1000);
        send_tick(1'b1, 1'b1, 16'sh7fff);
        send_tick(1'b0, 1'b1, 16'sd200);
        send_tick(1'b1, 1'b1, -16'sd1);
        drain();

        // combined mode: buttons run, reading sets duty
        load_config(rrdt_pkg::MODE_COMBINED, 16'd0, 16'd0, 16'd30000, 16'd100, 16'd40000);
        send_tick(1'b1, 1'b1, 16'sd150);
        send_tick(1'b0, 1'b1, 16'sd20000);
        send_tick(1'b1, 1'b0, -16'sd5);
        send_tick(1'b1, 1'b1, 16'sh7fff);
        drain();

        // widest limits, then zero full scale
        write_reg(rrdt_pkg::REG_UPPER, 16'hffff);
        write_reg(rrdt_pkg::REG_LOWER, 16'd0);
        send_tick(1'b0, 1'b1, 16'sh7fff);
        drain();
        write_reg(rrdt_pkg::REG_DUTY_FS, 16'd0);
        send_tick(1'b1, 1'b1, 16'sd12345);
        drain();

        // limits not ordered: equal, then inverted
        load_config(rrdt_pkg::MODE_POT, 16'hffff, 16'h8000, 16'd100, 16'd100, 16'hffff);
        send_tick(1'b1, 1'b1, 16'sd100);
        drain();
        write_reg(rrdt_pkg::REG_UPPER, 16'd50);
        send_tick(1'b1, 1'b1, 16'sd5000);
        drain();

        // unused mode holds everything; writes past the map are dropped
        write_reg(rrdt_pkg::REG_MODE, {14'($urandom), MODE_UNUSED});
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(REG_SPARE_HI, 16'($urandom));
        send_tick(1'b0, 1'b0, 16'sd1234);
        send_tick(1'b1, 1'b1, -16'sd1);

        // random phases, each with its own register setting
        start_lvl = 1'b1;
        stop_lvl  = 1'b1;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            r = $urandom_range(99);
            if (r < 25)
                mode_val = rrdt_pkg::MODE_BUTTONS;
            else if (r < 55)
                mode_val = rrdt_pkg::MODE_POT;
            else if (r < 92)
                mode_val = rrdt_pkg::MODE_COMBINED;
            else
                mode_val = MODE_UNUSED;
            start_val = pick_threshold();
            if ($urandom_range(99) < 30 || start_val > 16'h7fff)
                stop_val = pick_threshold();
            else
                stop_val = 16'($urandom_range(start_val));
            lower_val = ($urandom_range(99) < 10) ? 16'd0 : 16'($urandom_range(16000));
            r = $urandom_range(99);
            if (r < 8)
                upper_val = lower_val;
            else if (r < 15)
                upper_val = 16'($urandom_range(lower_val));
            else if (r < 22)
                upper_val = 16'hffff;
            else if (r < 27)
                upper_val = 16'h7fff;
            else
                upper_val = 16'(lower_val + $urandom_range(32767 - lower_val));
            r = $urandom_range(99);
            fs_val = (r < 10) ? 16'd0 : (r < 20) ? 16'hffff : 16'($urandom);
            load_config(mode_val, start_val, stop_val, upper_val, lower_val, fs_val);
            if ($urandom_range(99) < 10)
                write_reg(($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                          16'($urandom));

            // one stretch with no idling on either side
            steady = (phase >= 5 && phase <= 7);

            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                if ($urandom_range(99) < 10)
                begin
                    start_lvl = 1'($urandom);
                    stop_lvl  = 1'($urandom);
                end
                else
                begin
                    if ($urandom_range(99) < 20)
                        start_lvl = ~start_lvl;
                    if ($urandom_range(99) < 20)
                        stop_lvl = ~stop_lvl;
                end
                send_tick(start_lvl, stop_lvl, pick_reading());
            end
        end
        steady = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("run_request_and_duty_target_core_test passed");
        else
            $display("run_request_and_duty_target_core_test failed");
        $finish;
    end

endmodule
